/* rtl/skts_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_pkg
// Shared types and constants for the sorted key/value table search unit.
// ----------------------------------------------------------------------------
package skts_pkg;

   localparam int ENTRIES_DEFAULT = 64;
   localparam int QUEUE_DEPTH     = 2;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_GET    = 2'd2,
      OP_SCAN   = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]          op;
      logic signed [63:0]  key;
      logic signed [63:0]  end_key;
      logic signed [63:0]  value;
   } req_type;

   typedef struct packed {
      logic                found;
      logic signed [63:0]  out_key;
      logic signed [63:0]  out_value;
      logic                last;
   } rsp_type;

   typedef struct packed {
      op_type              op;
      logic                empty_range;
      logic signed [63:0]  key;
      logic signed [63:0]  end_key;
      logic signed [63:0]  value;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP,
      ST_GET_CHK,
      ST_SCAN_CHK,
      ST_SCAN_END
   } eng_state_type;

endpackage

/* rtl/skts_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_front
// Accepts request transactions, decodes the operation and flags scans whose
// bounds are crossed, then hands the command to the queue.
// ----------------------------------------------------------------------------
module skts_front import skts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    push,
   output cmd_type push_cmd,
   input  logic    q_full
);

   logic    valid_ff;
   logic    valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    accept;

   assign busy     = valid_ff && q_full;
   assign accept   = start && !busy;
   assign push     = valid_ff && !q_full;
   assign push_cmd = cmd_ff;

   always_comb begin
      cmd_in             = cmd_ff;
      valid_in           = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in           = 1'b1;
         cmd_in.op          = op_type'(req_data.op);
         cmd_in.key         = req_data.key;
         cmd_in.end_key     = req_data.end_key;
         cmd_in.value       = req_data.value;
         cmd_in.empty_range = $signed(req_data.key) > $signed(req_data.end_key);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

/* rtl/skts_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_queue
// Short command queue between the front and the search engine.
// ----------------------------------------------------------------------------
module skts_queue import skts_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type             slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_in;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    fill_in;

   assign full    = fill_ff == CNT_W'(QUEUE_DEPTH);
   assign empty   = fill_ff == '0;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !full) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
         fill_in = fill_ff + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push && !full) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/skts_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skts_engine
// Holds the key/value table and carries out clear, append, get (binary
// search) and range scan commands, one result per cycle during a scan.
// ----------------------------------------------------------------------------
module skts_engine import skts_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_empty,
   input  cmd_type q_cmd,
   output logic    pop,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic signed [63:0] key_mem [ENTRIES];
   logic signed [63:0] val_mem [ENTRIES];
   logic signed [63:0] rd_key_ff;
   logic signed [63:0] rd_val_ff;

   eng_state_type      state_ff;
   eng_state_type      state_in;
   cmd_type            cmd_ff;
   cmd_type            cmd_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic signed [63:0] first_key_ff;
   logic signed [63:0] first_key_in;
   logic signed [63:0] last_key_ff;
   logic signed [63:0] last_key_in;
   logic [CNT_W-1:0]   lo_ff;
   logic [CNT_W-1:0]   lo_in;
   logic [CNT_W-1:0]   hi_ff;
   logic [CNT_W-1:0]   hi_in;
   logic               have_pend_ff;
   logic               have_pend_in;
   logic signed [63:0] pend_key_ff;
   logic signed [63:0] pend_key_in;
   logic signed [63:0] pend_val_ff;
   logic signed [63:0] pend_val_in;
   logic               rsp_strobe_ff;
   logic               rsp_strobe_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [CNT_W-1:0]   mid;
   logic [CNT_W-1:0]   lo_next;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;
   logic               can_append;
   logic               get_in_range;

   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_next    = lo_ff + 1'b1;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   assign can_append = (count_ff < CNT_W'(ENTRIES))
                       && ((count_ff == '0) || ($signed(q_cmd.key) > last_key_ff));
   assign get_in_range = (count_ff != '0)
                         && ($signed(q_cmd.key) >= first_key_ff)
                         && ($signed(q_cmd.key) <= last_key_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      first_key_in  = first_key_ff;
      last_key_in   = last_key_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      have_pend_in  = have_pend_ff;
      pend_key_in   = pend_key_ff;
      pend_val_in   = pend_val_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = '0;
      pop           = 1'b0;
      wr_en         = 1'b0;
      rd_addr       = lo_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               lo_in  = '0;
               hi_in  = count_ff;
               case (q_cmd.op)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (can_append) begin
                        wr_en       = 1'b1;
                        count_in    = count_ff + 1'b1;
                        last_key_in = q_cmd.key;
                        if (count_ff == '0) begin
                           first_key_in = q_cmd.key;
                        end
                     end
                  end
                  OP_GET: begin
                     if (get_in_range) begin
                        state_in = ST_PROBE;
                     end else begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     if (q_cmd.empty_range) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.last   = 1'b1;
                     end else begin
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = mid[IDX_W-1:0];
               state_in = ST_CMP;
            end else if (cmd_ff.op == OP_GET) begin
               state_in = ST_GET_CHK;
            end else begin
               have_pend_in = 1'b0;
               state_in     = (lo_ff < count_ff) ? ST_SCAN_CHK : ST_SCAN_END;
            end
         end
         ST_CMP: begin
            if (rd_key_ff < $signed(cmd_ff.key)) begin
               lo_in = mid + 1'b1;
            end else begin
               hi_in = mid;
            end
            state_in = ST_PROBE;
         end
         ST_GET_CHK: begin
            rsp_strobe_in = 1'b1;
            rsp_in.last   = 1'b1;
            if (rd_key_ff == $signed(cmd_ff.key)) begin
               rsp_in.found     = 1'b1;
               rsp_in.out_key   = rd_key_ff;
               rsp_in.out_value = rd_val_ff;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN_CHK: begin
            if (rd_key_ff <= $signed(cmd_ff.end_key)) begin
               if (have_pend_ff) begin
                  rsp_strobe_in    = 1'b1;
                  rsp_in.found     = 1'b1;
                  rsp_in.out_key   = pend_key_ff;
                  rsp_in.out_value = pend_val_ff;
               end
               have_pend_in = 1'b1;
               pend_key_in  = rd_key_ff;
               pend_val_in  = rd_val_ff;
               lo_in        = lo_next;
               rd_addr      = lo_next[IDX_W-1:0];
               state_in     = (lo_next < count_ff) ? ST_SCAN_CHK : ST_SCAN_END;
            end else begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            rsp_strobe_in = 1'b1;
            rsp_in.last   = 1'b1;
            if (have_pend_ff) begin
               rsp_in.found     = 1'b1;
               rsp_in.out_key   = pend_key_ff;
               rsp_in.out_value = pend_val_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         have_pend_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         have_pend_ff  <= have_pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff       <= cmd_in;
      first_key_ff <= first_key_in;
      last_key_ff  <= last_key_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      pend_key_ff  <= pend_key_in;
      pend_val_ff  <= pend_val_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[count_ff[IDX_W-1:0]] <= q_cmd.key;
         val_mem[count_ff[IDX_W-1:0]] <= q_cmd.value;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
   end

endmodule

/* rtl/sorted_kv_table_search_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_kv_table_search_unit
// Sorted key/value table with binary-search get and ordered range scan.
// An accepted transaction passes the front's command register and the command
// queue to reach the engine. Clear and append finish in the idle state. A get
// passes a probe and a compare state per memory probe (7 probes for a full
// 64-entry table), then a check state. A scan probes alike, then walks the
// matching pairs, at most one result per cycle, via the registered read port.
// Reset empties the table and the command queue; results cannot be stalled.
// ----------------------------------------------------------------------------
module sorted_kv_table_search_unit import skts_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_empty;
   logic    pop;
   cmd_type pop_cmd;

   skts_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .push     (push),
      .push_cmd (push_cmd),
      .q_full   (q_full)
   );

   skts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (q_empty)
   );

   skts_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_cmd      (pop_cmd),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted key/value table search unit. Clear,
// append, get and range-scan transactions go in through the start/busy
// handshake with random gaps. A table model predicts the result stream, and
// every strobed result is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb import skts_pkg::*; ();

   localparam int TABLE_DEPTH = ENTRIES_DEFAULT;
   localparam logic signed [63:0] KEY_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [63:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] PAT_A   = 64'shAAAA_AAAA_AAAA_AAAA;
   localparam logic signed [63:0] PAT_5   = 64'sh5555_5555_5555_5555;
   localparam int RANDOM_ITEMS = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic signed [63:0] model_key [TABLE_DEPTH];
   logic signed [63:0] model_value [TABLE_DEPTH];
   int      model_count = 0;
   rsp_type expected_rsp_q [$];
   int      error_count = 0;
   int      items_sent = 0;
   bit      gapless = 1'b0;

   always #5 clock = ~clock;

   sorted_kv_table_search_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic rsp_type make_rsp(input bit found, input logic signed [63:0] k,
                                        input logic signed [63:0] v, input bit last);
      rsp_type r;
      r.found     = found;
      r.out_key   = k;
      r.out_value = v;
      r.last      = last;
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (gapless || roll < 50)
         return 0;
      if (roll < 90)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic logic signed [63:0] stored_key();
      return model_key[$urandom_range(model_count - 1)];
   endfunction

   task automatic queue_expected(input rsp_type r);
      expected_rsp_q.insert(expected_rsp_q.size(), r);
   endtask

   // update the table model and queue the results one transaction causes
   task automatic predict_table(input req_type r);
      logic signed [63:0] k;
      logic signed [63:0] e;
      rsp_type pending;
      bit      have_pending;
      k = r.key;
      e = r.end_key;
      have_pending = 1'b0;
      pending = make_rsp(1'b0, 64'sd0, 64'sd0, 1'b1);
      case (op_type'(r.op))
         OP_CLEAR: begin
            model_count = 0;
         end
         OP_APPEND: begin
            if (model_count < TABLE_DEPTH &&
                (model_count == 0 || k > model_key[model_count - 1])) begin
               model_key[model_count]   = k;
               model_value[model_count] = r.value;
               model_count++;
            end
         end
         OP_GET: begin
            if (model_count > 0 && k >= model_key[0] && k <= model_key[model_count - 1])
               for (int i = 0; i < model_count; i++)
                  if (model_key[i] == k)
                     pending = make_rsp(1'b1, model_key[i], model_value[i], 1'b1);
            queue_expected(pending);
         end
         OP_SCAN: begin
            for (int i = 0; i < model_count; i++) begin
               if (model_key[i] >= k && model_key[i] <= e) begin
                  if (have_pending)
                     queue_expected(pending);
                  pending = make_rsp(1'b1, model_key[i], model_value[i], 1'b0);
                  have_pending = 1'b1;
               end
            end
            pending.last = 1'b1;
            queue_expected(pending);
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_item(input op_type op, input logic signed [63:0] k,
                            input logic signed [63:0] e, input logic signed [63:0] v);
      req_type r;
      int      gap;
      r.op      = op;
      r.key     = k;
      r.end_key = e;
      r.value   = v;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_table(r);
      items_sent++;
   endtask

   // hold the request side until every queued result has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp_q.size() == 0) begin
            error_count++;
            if (error_count <= 40)
               $display("%0t: unexpected result: expected none, got found=%0b key=%0h",
                        $time, rsp_data.found, rsp_data.out_key,
                        " value=%0h last=%0b", rsp_data.out_value, rsp_data.last);
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.found !== want.found || rsp_data.out_key !== want.out_key ||
                rsp_data.out_value !== want.out_value || rsp_data.last !== want.last) begin
               error_count++;
               if (error_count <= 40)
                  $display("%0t: mismatch: expected found=%0b key=%0h value=%0h last=%0b,",
                           $time, want.found, want.out_key, want.out_value, want.last,
                           " got found=%0b key=%0h value=%0h last=%0b",
                           rsp_data.found, rsp_data.out_key, rsp_data.out_value,
                           rsp_data.last);
            end
         end
      end
   end

   task automatic test_directed();
      send_item(OP_GET, 64'sd0, 64'sd0, 64'sd0);
      send_item(OP_SCAN, KEY_MIN, KEY_MAX, 64'sd0);
      send_item(OP_APPEND, KEY_MIN, 64'sd0, KEY_MAX);
      send_item(OP_APPEND, KEY_MIN, 64'sd0, 64'sd1);
      send_item(OP_APPEND, 64'sd0, PAT_A, PAT_5);
      send_item(OP_APPEND, -64'sd5, 64'sd0, 64'sd3);
      send_item(OP_APPEND, KEY_MAX, PAT_5, KEY_MIN);
      send_item(OP_GET, KEY_MIN, 64'sd0, 64'sd0);
      send_item(OP_GET, KEY_MAX, 64'sd0, 64'sd0);
      send_item(OP_GET, 64'sd0, 64'sd0, 64'sd0);
      send_item(OP_GET, 64'sd7, 64'sd0, 64'sd0);
      send_item(OP_GET, -64'sd1, 64'sd0, 64'sd0);
      send_item(OP_SCAN, KEY_MIN, KEY_MAX, 64'sd0);
      send_item(OP_SCAN, KEY_MAX, KEY_MIN, 64'sd0);
      send_item(OP_SCAN, 64'sd1, 64'sd100, 64'sd0);
      send_item(OP_SCAN, KEY_MAX, KEY_MAX, 64'sd0);
      send_item(OP_SCAN, KEY_MIN, KEY_MIN, 64'sd0);
      send_item(OP_SCAN, -64'sd1, 64'sd0, 64'sd0);
      send_item(OP_CLEAR, PAT_A, PAT_5, PAT_A);
      send_item(OP_GET, KEY_MIN, 64'sd0, 64'sd0);
      send_item(OP_SCAN, KEY_MIN, KEY_MAX, 64'sd0);
      send_item(OP_APPEND, PAT_5, 64'sd0, PAT_A);
      send_item(OP_GET, PAT_5, 64'sd0, 64'sd0);
      wait_drained();
   endtask

   task automatic test_full_table();
      logic signed [63:0] k;
      gapless = 1'b1;
      send_item(OP_CLEAR, 64'sd0, 64'sd0, 64'sd0);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         k = KEY_MIN + (64'(i) << 58) + 64'($urandom_range(1000));
         send_item(OP_APPEND, k, rand64(), rand64());
      end
      send_item(OP_APPEND, KEY_MAX, 64'sd0, 64'sd1);
      send_item(OP_GET, KEY_MAX, 64'sd0, 64'sd0);
      send_item(OP_GET, stored_key(), 64'sd0, 64'sd0);
      send_item(OP_SCAN, KEY_MIN, KEY_MAX, 64'sd0);
      gapless = 1'b0;
      send_item(OP_SCAN, model_key[10], model_key[20], 64'sd0);
      send_item(OP_GET, model_key[0], 64'sd0, 64'sd0);
      send_item(OP_GET, model_key[TABLE_DEPTH - 1], 64'sd0, 64'sd0);
      wait_drained();
   endtask

   task automatic test_random_sequences();
      logic signed [63:0] k;
      logic signed [63:0] e;
      logic signed [63:0] pk;
      int n;
      int queries;
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         gapless = ($urandom_range(3) == 0);
         if ($urandom_range(3) != 0)
            send_item(OP_CLEAR, rand64(), rand64(), rand64());
         n = $urandom_range(12, 1);
         pk = ($urandom_range(1) == 0) ? rand64() : KEY_MIN + 64'($urandom_range(15));
         if (model_count > 0)
            pk = model_key[model_count - 1];
         else
            send_item(OP_APPEND, pk, rand64(), rand64());
         for (int i = 1; i < n; i++) begin
            if ($urandom_range(7) == 0) begin
               send_item(OP_APPEND, pk - 64'($urandom_range(1)), rand64(), rand64());
            end else begin
               k = pk + 64'(rand64() >> $urandom_range(63, 4)) + 64'sd1;
               if (k <= pk)
                  k = $urandom_range(1) ? KEY_MAX : rand64();
               send_item(OP_APPEND, k, rand64(), rand64());
               if (model_count > 0)
                  pk = model_key[model_count - 1];
            end
         end
         queries = $urandom_range(8, 2);
         for (int j = 0; j < queries; j++) begin
            if (model_count > 0 && $urandom_range(9) < 7)
               k = stored_key() + 64'($urandom_range(9) == 0);
            else
               k = rand64();
            if ($urandom_range(9) < 6) begin
               send_item(OP_GET, k, rand64(), rand64());
            end else begin
               if (model_count > 0 && $urandom_range(2) != 0)
                  e = stored_key();
               else
                  e = k + 64'(rand64() >> $urandom_range(63, 1));
               send_item(OP_SCAN, k, e, rand64());
            end
         end
         if ($urandom_range(4) == 0)
            wait_drained();
      end
      gapless = 1'b0;
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_table();
      test_random_sequences();
      repeat (30) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

/* filelist.f */
rtl/skts_pkg.sv
rtl/skts_front.sv
rtl/skts_queue.sv
rtl/skts_engine.sv
rtl/sorted_kv_table_search_unit.sv
bench/tb.sv
